@@ design/ibs_pkg.sv @@
package ibs_pkg;

    localparam int PATTERN_ENTRIES = 5;
    localparam int ENTRY_BITS      = 9;
    localparam int COUNT_BITS      = 8;
    localparam int INDEX_BITS      = 3;
    localparam int MAX_ENTRIES     = 2 ** INDEX_BITS;
    localparam int PATTERN_WIDTH   = PATTERN_ENTRIES * ENTRY_BITS;
    localparam int KEYS            = 2;
    localparam int CFG_INDEX_BITS  = 1;

    localparam logic [PATTERN_WIDTH-1:0] PATTERN_IMMEDIATE_RESET = 45'd36571324516;
    localparam logic [PATTERN_WIDTH-1:0] PATTERN_DELAYED_RESET   = 45'd36554023012;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PATTERN_IMMEDIATE = 1'b0,
        CFG_PATTERN_DELAYED   = 1'b1
    } cfg_index_t;

    typedef enum logic {
        CMD_KEY_SAMPLE = 1'b0,
        CMD_CARRIER    = 1'b1
    } command_t;

    typedef enum logic {
        SEL_IMMEDIATE = 1'b0,
        SEL_DELAYED   = 1'b1
    } pattern_sel_t;

    typedef struct packed {
        logic                  playing;
        logic                  led_on;
        logic [INDEX_BITS-1:0] point_index;
        logic [COUNT_BITS-1:0] ticks_left;
        logic                  pattern_select;
        logic                  pattern_started;
        logic                  pattern_done;
        logic                  checking;
        logic [KEYS-1:0]       keys_debounced;
    } result_t;

    function automatic logic [ENTRY_BITS-1:0] entry_of(
        input logic [PATTERN_WIDTH-1:0] pattern,
        input logic [INDEX_BITS-1:0]    idx
    );
        logic [MAX_ENTRIES*ENTRY_BITS-1:0] ext;
        ext = {{(MAX_ENTRIES*ENTRY_BITS-PATTERN_WIDTH){1'b0}}, pattern};
        return ext[ENTRY_BITS*idx +: ENTRY_BITS];
    endfunction

endpackage

@@ design/ibs_if.sv @@
interface ibs_in_if;
    import ibs_pkg::*;
    logic            valid;
    logic            ready;
    logic            command;
    logic [KEYS-1:0] key_pins;
    modport source (output valid, command, key_pins, input ready);
    modport sink (input valid, command, key_pins, output ready);
endinterface

interface ibs_cfg_if;
    import ibs_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [PATTERN_WIDTH-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

interface ibs_out_if;
    import ibs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  playing;
    logic                  led_on;
    logic [INDEX_BITS-1:0] point_index;
    logic [COUNT_BITS-1:0] ticks_left;
    logic                  pattern_select;
    logic                  pattern_started;
    logic                  pattern_done;
    logic                  checking;
    logic [KEYS-1:0]       keys_debounced;
    modport source (
        output valid, playing, led_on, point_index, ticks_left, pattern_select,
               pattern_started, pattern_done, checking, keys_debounced,
        input  ready
    );
    modport sink (
        input  valid, playing, led_on, point_index, ticks_left, pattern_select,
               pattern_started, pattern_done, checking, keys_debounced,
        output ready
    );
endinterface

@@ design/ir_burst_sequencer_with_debounce.sv @@
// A result beat is registered in the output buffer, head or tail, before it is offered.
// Throughput: one item per cycle unless the output buffer is full; all of the
// work for an item is one pass of the debounce and sequencing logic into the state registers.
// A two-beat output buffer lets items keep arriving while one result waits.
// Reset: idle, keys released, counters all ones, both patterns at their defaults.
module ir_burst_sequencer_with_debounce #(
    parameter int CHECK_SAMPLES = 5
) (
    input logic       clk,
    input logic       rst_n,
    ibs_in_if.sink    items,
    ibs_cfg_if.sink   cfg,
    ibs_out_if.source results
);
    import ibs_pkg::*;

    logic    buf_ready;
    logic    push_valid;
    result_t push_data;

    ibs_core #(
        .CHECK_SAMPLES(CHECK_SAMPLES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .cfg        (cfg),
        .buf_ready  (buf_ready),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    ibs_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (buf_ready),
        .results    (results)
    );

endmodule

@@ design/ibs_core.sv @@
module ibs_core #(
    parameter int CHECK_SAMPLES = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    ibs_in_if.sink           items,
    ibs_cfg_if.sink          cfg,
    input  logic             buf_ready,
    output logic             push_valid,
    output ibs_pkg::result_t push_data
);
    import ibs_pkg::*;

    localparam int SC_W = $clog2(CHECK_SAMPLES + 1);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_CHECK = 2'd1,
        PH_PLAY  = 2'd2
    } phase_t;

    logic [PATTERN_WIDTH-1:0] pat_imm_reg, pat_del_reg;
    logic [KEYS-1:0]          deb_reg, deb_next;
    logic [KEYS-1:0]          cnt_lo_reg, cnt_lo_next;
    logic [KEYS-1:0]          cnt_hi_reg, cnt_hi_next;
    logic [KEYS-1:0]          latch_reg, latch_next;
    logic [KEYS-1:0]          last_pins_reg;
    phase_t                   phase_reg, phase_next;
    logic [SC_W-1:0]          samples_reg, samples_next;
    logic                     which_reg, which_next;
    logic [INDEX_BITS-1:0]    entry_reg, entry_next;
    logic [COUNT_BITS-1:0]    ticks_reg, ticks_next;
    logic                     enable_reg, enable_next;
    logic                     started, done;

    logic                     accept;
    logic [KEYS-1:0]          flip, settled;
    logic [COUNT_BITS-1:0]    ticks_dec;
    logic [INDEX_BITS:0]      step_idx;
    logic [INDEX_BITS:0]      fetch_idx;
    logic [ENTRY_BITS-1:0]    fetched;
    logic                     load;

    assign accept      = items.valid && items.ready;
    assign items.ready = buf_ready;
    assign cfg.ready   = 1'b1;

    assign flip        = (~items.key_pins) ^ deb_reg;
    assign ticks_dec   = (ticks_reg != '0) ? ticks_reg - 1'b1 : ticks_reg;
    assign step_idx    = {1'b0, entry_reg} + 1'b1;

    always_comb
    begin
        deb_next     = deb_reg;
        cnt_lo_next  = cnt_lo_reg;
        cnt_hi_next  = cnt_hi_reg;
        latch_next   = latch_reg;
        phase_next   = phase_reg;
        samples_next = samples_reg;
        which_next   = which_reg;
        entry_next   = entry_reg;
        ticks_next   = ticks_reg;
        enable_next  = enable_reg;
        started      = 1'b0;
        done         = 1'b0;
        load         = 1'b0;
        fetch_idx    = '0;
        settled      = '0;
        case (phase_reg)
            PH_CHECK:
            begin
                if (items.command == CMD_KEY_SAMPLE)
                begin
                    cnt_lo_next  = ~(cnt_lo_reg & flip);
                    cnt_hi_next  = cnt_lo_next ^ (cnt_hi_reg & flip);
                    settled      = flip & cnt_lo_next & cnt_hi_next;
                    deb_next     = deb_reg ^ settled;
                    latch_next   = latch_reg | (deb_next & settled);
                    samples_next = samples_reg + 1'b1;
                    if (samples_next >= SC_W'(CHECK_SAMPLES))
                    begin
                        if (latch_next[0])
                        begin
                            latch_next[0] = 1'b0;
                            which_next    = SEL_IMMEDIATE;
                            load          = 1'b1;
                        end
                        else if (latch_next[1])
                        begin
                            latch_next[1] = 1'b0;
                            which_next    = SEL_DELAYED;
                            load          = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                        if (load)
                        begin
                            phase_next = PH_PLAY;
                            started    = 1'b1;
                        end
                    end
                end
            end
            PH_PLAY:
            begin
                if (items.command == CMD_CARRIER)
                begin
                    ticks_next = ticks_dec;
                    if (ticks_dec == '0)
                    begin
                        load      = 1'b1;
                        fetch_idx = step_idx;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (items.key_pins != last_pins_reg)
                begin
                    phase_next   = PH_CHECK;
                    samples_next = '0;
                end
            end
        endcase

        fetched = entry_of((which_next == SEL_DELAYED) ? pat_del_reg : pat_imm_reg,
                           fetch_idx[INDEX_BITS-1:0]);
        if (fetch_idx >= (INDEX_BITS + 1)'(PATTERN_ENTRIES))
            fetched = '0;

        if (load)
        begin
            if (fetched[COUNT_BITS-1:0] == '0)
            begin
                phase_next  = PH_IDLE;
                entry_next  = '0;
                ticks_next  = '0;
                enable_next = 1'b0;
                done        = 1'b1;
            end
            else
            begin
                entry_next  = fetch_idx[INDEX_BITS-1:0];
                ticks_next  = fetched[COUNT_BITS-1:0];
                enable_next = fetched[ENTRY_BITS-1];
            end
        end
    end

    always_comb
    begin
        push_valid                = accept;
        push_data.playing         = (phase_next == PH_PLAY);
        push_data.led_on          = (phase_next == PH_PLAY) ? enable_next : 1'b0;
        push_data.point_index     = (phase_next == PH_PLAY) ? entry_next : '0;
        push_data.ticks_left      = (phase_next == PH_PLAY) ? ticks_next : '0;
        push_data.pattern_select  = which_next;
        push_data.pattern_started = started;
        push_data.pattern_done    = done;
        push_data.checking        = (phase_next == PH_CHECK);
        push_data.keys_debounced  = deb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_imm_reg   <= PATTERN_IMMEDIATE_RESET;
            pat_del_reg   <= PATTERN_DELAYED_RESET;
            deb_reg       <= '0;
            cnt_lo_reg    <= '1;
            cnt_hi_reg    <= '1;
            latch_reg     <= '0;
            last_pins_reg <= '1;
            phase_reg     <= PH_IDLE;
            samples_reg   <= '0;
            which_reg     <= SEL_IMMEDIATE;
            entry_reg     <= '0;
            ticks_reg     <= '0;
            enable_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_PATTERN_IMMEDIATE: pat_imm_reg <= cfg.data;
                    CFG_PATTERN_DELAYED:   pat_del_reg <= cfg.data;
                    default:               ;
                endcase
            end
            if (accept)
            begin
                deb_reg       <= deb_next;
                cnt_lo_reg    <= cnt_lo_next;
                cnt_hi_reg    <= cnt_hi_next;
                latch_reg     <= latch_next;
                last_pins_reg <= items.key_pins;
                phase_reg     <= phase_next;
                samples_reg   <= samples_next;
                which_reg     <= which_next;
                entry_reg     <= entry_next;
                ticks_reg     <= ticks_next;
                enable_reg    <= enable_next;
            end
        end
    end

    a_play_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PLAY |-> ticks_reg != '0)
        else $error("playing with an empty entry");

    a_play_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PLAY |-> entry_reg < INDEX_BITS'(PATTERN_ENTRIES))
        else $error("entry index beyond table");

    a_check_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CHECK |-> samples_reg < SC_W'(CHECK_SAMPLES))
        else $error("check phase outlived its sample count");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && done |=> phase_reg == PH_IDLE)
        else $error("pattern ended but phase not idle");

endmodule

@@ design/ibs_out_buf.sv @@
module ibs_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  ibs_pkg::result_t push_data,
    output logic             push_ready,
    ibs_out_if.source        results
);
    import ibs_pkg::*;

    result_t head_reg, head_next;
    result_t tail_reg, tail_next;
    logic    head_valid_reg, head_valid_next;
    logic    tail_valid_reg, tail_valid_next;
    logic    pop, push;

    assign push_ready = !tail_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = head_valid_reg && results.ready;

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        if (!head_valid_reg || pop)
        begin
            if (tail_valid_reg)
            begin
                head_next       = tail_reg;
                tail_valid_next = 1'b0;
            end
            else
            begin
                head_next       = push_data;
                head_valid_next = push;
            end
        end
        else if (push)
        begin
            tail_next       = push_data;
            tail_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign results.valid           = head_valid_reg;
    assign results.playing         = head_reg.playing;
    assign results.led_on          = head_reg.led_on;
    assign results.point_index     = head_reg.point_index;
    assign results.ticks_left      = head_reg.ticks_left;
    assign results.pattern_select  = head_reg.pattern_select;
    assign results.pattern_started = head_reg.pattern_started;
    assign results.pattern_done    = head_reg.pattern_done;
    assign results.checking        = head_reg.checking;
    assign results.keys_debounced  = head_reg.keys_debounced;

    a_tail_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid_reg |-> head_valid_reg)
        else $error("second beat held without a first");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid_reg && !results.ready |=> head_valid_reg && $stable(head_reg))
        else $error("waiting beat changed");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid_reg && !results.ready |=> tail_valid_reg && $stable(tail_reg))
        else $error("held beat overwritten");

endmodule
